// ===== design/pda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pda_pkg
// Shared types, constants and helpers of the Poisson disc accept/insert engine
// ----------------------------------------------------------------------------
package pda_pkg;

   localparam int GRID_CELLS   = 4096;
   localparam int GRID_AW      = $clog2(GRID_CELLS);
   localparam int CNT_W        = GRID_AW + 1;
   localparam int SEARCH_REACH = 2;
   localparam int COORD_BITS   = 24;

   localparam int REGION_W  = 23;
   localparam int RECIP_W   = 24;
   localparam int DIM_W     = 13;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 24;

   localparam int POS_W       = REGION_W;
   localparam int CMP_W       = (COORD_BITS > REGION_W) ? COORD_BITS : REGION_W + 1;
   localparam int CELL_SHIFT  = 24;
   localparam int PROD_W      = POS_W + RECIP_W;
   localparam int SQ_W        = 2 * POS_W;
   localparam int FULL_ADDR_W = 2 * DIM_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REGION_WIDTH  = 3'd0,
      CSR_REGION_HEIGHT = 3'd1,
      CSR_MIN_DISTANCE  = 3'd2,
      CSR_CELL_RECIP    = 3'd3,
      CSR_GRID_COLS     = 3'd4,
      CSR_GRID_ROWS     = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_ACCEPTED  = 2'd0,
      ST_OUTSIDE   = 2'd1,
      ST_TOO_CLOSE = 2'd2,
      ST_CLEARED   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_CLEAR   = 2'd0,
      KIND_OUTSIDE = 2'd1,
      KIND_TEST    = 2'd2
   } kind_type;

   typedef struct packed {
      logic [REGION_W-1:0] region_width;
      logic [REGION_W-1:0] region_height;
      logic [REGION_W-1:0] min_distance;
      logic [RECIP_W-1:0]  cell_reciprocal;
      logic [DIM_W-1:0]    grid_cols;
      logic [DIM_W-1:0]    grid_rows;
   } cfg_type;

   typedef struct packed {
      kind_type         kind;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [DIM_W-1:0] cx;
      logic [DIM_W-1:0] cy;
   } qentry_type;

   // a stored point remembers which grid cell it marked, so stale grid
   // entries left over from before a clear can be told apart
   typedef struct packed {
      logic [POS_W-1:0]   x;
      logic [POS_W-1:0]   y;
      logic               marked;
      logic [GRID_AW-1:0] cell_addr;
   } point_type;

   localparam int PT_W = $bits(point_type);

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] count);
      return (count == '0) ? DIM_W'(1) : count;
   endfunction

   function automatic logic [DIM_W-1:0] clamp_cell(input logic [PROD_W-1:0] prod,
                                                    input logic [DIM_W-1:0]  count);
      logic [DIM_W-1:0]  lim;
      logic [PROD_W-1:0] quot;
      lim  = eff_dim(count) - DIM_W'(1);
      quot = prod >> CELL_SHIFT;
      return (quot > PROD_W'(lim)) ? lim : quot[DIM_W-1:0];
   endfunction

endpackage

// ===== design/pda_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pda_ram
// Generic single write, single read RAM with registered read data
// ----------------------------------------------------------------------------
module pda_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/pda_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pda_front
// Takes a transaction, checks the region and works out the grid cell
// ----------------------------------------------------------------------------
module pda_front import pda_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_operation,
   input  logic [COORD_BITS-1:0] req_candidate_x,
   input  logic [COORD_BITS-1:0] req_candidate_y,
   output logic                  push,
   output qentry_type            push_data,
   input  logic                  full
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_MUL  = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type state_ff, state_in;

   logic                  op_ff;
   logic [COORD_BITS-1:0] x_ff, y_ff;
   logic                  outside_ff;
   logic [POS_W-1:0]      xpos_ff, ypos_ff;
   logic [PROD_W-1:0]     px_ff, py_ff;

   logic [CMP_W-1:0] x_ext, y_ext;
   logic             outside_in;

   assign x_ext = CMP_W'(x_ff);
   assign y_ext = CMP_W'(y_ff);

   assign outside_in = x_ff[COORD_BITS-1] || y_ff[COORD_BITS-1]
                       || (x_ext >= CMP_W'(cfg.region_width))
                       || (y_ext >= CMP_W'(cfg.region_height));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: if (start) state_in = F_MUL;
         F_MUL:  state_in = F_PUSH;
         F_PUSH: if (!full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && start) begin
         op_ff <= req_operation;
         x_ff  <= req_candidate_x;
         y_ff  <= req_candidate_y;
      end
      if (state_ff == F_MUL) begin
         outside_ff <= outside_in;
         xpos_ff    <= x_ext[POS_W-1:0];
         ypos_ff    <= y_ext[POS_W-1:0];
         px_ff      <= PROD_W'(x_ext[POS_W-1:0]) * PROD_W'(cfg.cell_reciprocal);
         py_ff      <= PROD_W'(y_ext[POS_W-1:0]) * PROD_W'(cfg.cell_reciprocal);
      end
   end

   always_comb begin
      push_data.kind = !op_ff ? KIND_CLEAR : (outside_ff ? KIND_OUTSIDE : KIND_TEST);
      push_data.x    = xpos_ff;
      push_data.y    = ypos_ff;
      push_data.cx   = clamp_cell(px_ff, cfg.grid_cols);
      push_data.cy   = clamp_cell(py_ff, cfg.grid_rows);
   end

   assign push = (state_ff == F_PUSH) && !full;
   assign busy = (state_ff != F_IDLE);

endmodule

// ===== design/pda_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pda_queue
// Short FIFO of classified transactions between front and back
// ----------------------------------------------------------------------------
module pda_queue import pda_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  qentry_type push_data,
   output logic       full,
   input  logic       pop,
   output qentry_type pop_data,
   output logic       empty
);

   qentry_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, rd_ff;
   logic [QCNT_W-1:0]   cnt_ff;

   assign full     = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + QPTR_W'(1);
         if (pop)  rd_ff <= (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + QPTR_W'(1);
         if (push && !pop) begin
            cnt_ff <= cnt_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== design/pda_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pda_back
// Scans the neighbouring cells, checks distances and stores accepted points
// ----------------------------------------------------------------------------
module pda_back import pda_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               empty,
   input  qentry_type         pop_data,
   output logic               pop,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [GRID_AW-1:0] rsp_point_index,
   output logic [CNT_W-1:0]   rsp_points_stored
);

   typedef enum logic [8:0] {
      B_IDLE  = 9'b0_0000_0001,
      B_SETUP = 9'b0_0000_0010,
      B_BASE  = 9'b0_0000_0100,
      B_GRD   = 9'b0_0000_1000,
      B_GCHK  = 9'b0_0001_0000,
      B_PCHK  = 9'b0_0010_0000,
      B_DIST  = 9'b0_0100_0000,
      B_INS   = 9'b0_1000_0000,
      B_WIPE  = 9'b1_0000_0000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [CNT_W-1:0]       total_ff, total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [GRID_AW-1:0]     rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0]       rsp_stored_ff, rsp_stored_in;
   logic [GRID_AW-1:0]     wipe_ff;

   qentry_type             ent_ff;
   logic [DIM_W-1:0]       sx_ff, ex_ff, sy_ff, ey_ff, gx_ff, gy_ff;
   logic [SQ_W-1:0]        lim2_ff, dx2_ff, dy2_ff;
   logic [FULL_ADDR_W-1:0] colbase_ff, insaddr_ff;
   logic [GRID_AW-1:0]     cur_addr_ff;

   logic [DIM_W-1:0]       rows_eff, cols_eff;
   logic [DIM_W:0]         cx_hi, cy_hi;
   logic [FULL_ADDR_W-1:0] grid_addr;
   logic                   grid_in_range, ins_in_range;
   logic                   last_row, last_col;

   logic                   grid_re, pt_re, ins_we;
   logic                   grid_we;
   logic [GRID_AW-1:0]     grid_waddr;
   logic [CNT_W-1:0]       grid_wdata;
   logic [CNT_W-1:0]       grid_rdata, mark;
   logic                   mark_live;
   logic [PT_W-1:0]        pt_rdata;
   point_type              prec, new_pt;
   logic                   same_cell;
   logic [POS_W-1:0]       adx, ady;
   logic [SQ_W:0]          d2;
   logic                   store_full;

   assign rows_eff = eff_dim(cfg.grid_rows);
   assign cols_eff = eff_dim(cfg.grid_cols);
   assign cx_hi    = (DIM_W + 1)'(ent_ff.cx) + (DIM_W + 1)'(SEARCH_REACH);
   assign cy_hi    = (DIM_W + 1)'(ent_ff.cy) + (DIM_W + 1)'(SEARCH_REACH);

   assign grid_addr     = colbase_ff + FULL_ADDR_W'(gy_ff);
   assign grid_in_range = grid_addr < FULL_ADDR_W'(GRID_CELLS);
   assign ins_in_range  = insaddr_ff < FULL_ADDR_W'(GRID_CELLS);
   assign last_row      = (gy_ff == ey_ff);
   assign last_col      = (gx_ff == ex_ff);

   // a mark counts only if it names a point written since the last clear
   assign mark      = grid_rdata;
   assign mark_live = (mark != '0) && (mark <= total_ff);

   assign prec      = point_type'(pt_rdata);
   assign same_cell = prec.marked && (prec.cell_addr == cur_addr_ff);
   assign adx       = (ent_ff.x >= prec.x) ? ent_ff.x - prec.x : prec.x - ent_ff.x;
   assign ady       = (ent_ff.y >= prec.y) ? ent_ff.y - prec.y : prec.y - ent_ff.y;
   assign d2        = (SQ_W + 1)'(dx2_ff) + (SQ_W + 1)'(dy2_ff);

   assign store_full = (total_ff >= CNT_W'(GRID_CELLS));

   assign grid_re = (state_ff == B_GRD) && grid_in_range;
   assign pt_re   = (state_ff == B_GCHK) && mark_live;
   assign ins_we  = (state_ff == B_INS) && !store_full;
   assign pop     = (state_ff == B_IDLE) && !empty;

   // the grid is zeroed once after reset, one entry per cycle
   assign grid_we    = (state_ff == B_WIPE) || (ins_we && ins_in_range);
   assign grid_waddr = (state_ff == B_WIPE) ? wipe_ff : insaddr_ff[GRID_AW-1:0];
   assign grid_wdata = (state_ff == B_WIPE) ? '0 : total_ff + CNT_W'(1);

   always_comb begin
      new_pt.x         = ent_ff.x;
      new_pt.y         = ent_ff.y;
      new_pt.marked    = ins_in_range;
      new_pt.cell_addr = insaddr_ff[GRID_AW-1:0];
   end

   pda_ram #(
      .WIDTH (CNT_W),
      .DEPTH (GRID_CELLS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (grid_we),
      .wr_addr (grid_waddr),
      .wr_data (grid_wdata),
      .rd_en   (grid_re),
      .rd_addr (grid_addr[GRID_AW-1:0]),
      .rd_data (grid_rdata)
   );

   pda_ram #(
      .WIDTH (PT_W),
      .DEPTH (GRID_CELLS)
   ) u_points (
      .clock   (clock),
      .wr_en   (ins_we),
      .wr_addr (total_ff[GRID_AW-1:0]),
      .wr_data (PT_W'(new_pt)),
      .rd_en   (pt_re),
      .rd_addr (GRID_AW'(mark - CNT_W'(1))),
      .rd_data (pt_rdata)
   );

   // control path
   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_ACCEPTED;
      rsp_index_in  = '0;
      rsp_stored_in = total_ff;
      case (state_ff)
         B_WIPE: begin
            if (wipe_ff == GRID_AW'(GRID_CELLS - 1)) state_in = B_IDLE;
         end
         B_IDLE: begin
            if (!empty) begin
               case (pop_data.kind)
                  KIND_CLEAR: begin
                     total_in      = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_CLEARED;
                     rsp_stored_in = '0;
                  end
                  KIND_OUTSIDE: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OUTSIDE;
                  end
                  default: state_in = B_SETUP;
               endcase
            end
         end
         B_SETUP: state_in = B_BASE;
         B_BASE:  state_in = B_GRD;
         B_GRD: begin
            if (grid_in_range) begin
               state_in = B_GCHK;
            end else begin
               state_in = (last_row && last_col) ? B_INS : B_GRD;
            end
         end
         B_GCHK: begin
            if (mark_live) begin
               state_in = B_PCHK;
            end else begin
               state_in = (last_row && last_col) ? B_INS : B_GRD;
            end
         end
         B_PCHK: begin
            if (same_cell) begin
               state_in = B_DIST;
            end else begin
               state_in = (last_row && last_col) ? B_INS : B_GRD;
            end
         end
         B_DIST: begin
            if (d2 < (SQ_W + 1)'(lim2_ff)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_TOO_CLOSE;
               state_in      = B_IDLE;
            end else begin
               state_in = (last_row && last_col) ? B_INS : B_GRD;
            end
         end
         B_INS: begin
            rsp_valid_in = 1'b1;
            state_in     = B_IDLE;
            if (store_full) begin
               rsp_status_in = ST_TOO_CLOSE;
            end else begin
               total_in      = total_ff + CNT_W'(1);
               rsp_status_in = ST_ACCEPTED;
               rsp_index_in  = total_ff[GRID_AW-1:0];
               rsp_stored_in = total_ff + CNT_W'(1);
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_WIPE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         wipe_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == B_WIPE) begin
            wipe_ff <= wipe_ff + GRID_AW'(1);
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_stored_ff <= rsp_stored_in;
      if (pop) begin
         ent_ff <= pop_data;
      end
      case (state_ff)
         B_SETUP: begin
            sx_ff   <= (ent_ff.cx > DIM_W'(SEARCH_REACH))
                       ? ent_ff.cx - DIM_W'(SEARCH_REACH) : '0;
            sy_ff   <= (ent_ff.cy > DIM_W'(SEARCH_REACH))
                       ? ent_ff.cy - DIM_W'(SEARCH_REACH) : '0;
            ex_ff   <= (cx_hi < (DIM_W + 1)'(cols_eff - DIM_W'(1)))
                       ? cx_hi[DIM_W-1:0] : cols_eff - DIM_W'(1);
            ey_ff   <= (cy_hi < (DIM_W + 1)'(rows_eff - DIM_W'(1)))
                       ? cy_hi[DIM_W-1:0] : rows_eff - DIM_W'(1);
            lim2_ff <= SQ_W'(cfg.min_distance) * SQ_W'(cfg.min_distance);
         end
         B_BASE: begin
            gx_ff      <= sx_ff;
            gy_ff      <= sy_ff;
            colbase_ff <= FULL_ADDR_W'(sx_ff) * FULL_ADDR_W'(rows_eff);
            insaddr_ff <= FULL_ADDR_W'(ent_ff.cx) * FULL_ADDR_W'(rows_eff)
                          + FULL_ADDR_W'(ent_ff.cy);
         end
         B_PCHK: begin
            dx2_ff <= SQ_W'(adx) * SQ_W'(adx);
            dy2_ff <= SQ_W'(ady) * SQ_W'(ady);
         end
         default: ;
      endcase
      if (state_ff == B_GRD) begin
         cur_addr_ff <= grid_addr[GRID_AW-1:0];
      end
      // step to the next cell of the window, column by column
      if (((state_ff == B_GRD) && !grid_in_range) || ((state_ff == B_GCHK) && !mark_live)
          || ((state_ff == B_PCHK) && !same_cell)
          || ((state_ff == B_DIST) && !(d2 < (SQ_W + 1)'(lim2_ff)))) begin
         if (last_row) begin
            gy_ff      <= sy_ff;
            gx_ff      <= gx_ff + DIM_W'(1);
            colbase_ff <= colbase_ff + FULL_ADDR_W'(rows_eff);
         end else begin
            gy_ff <= gy_ff + DIM_W'(1);
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_point_index   = rsp_index_ff;
   assign rsp_points_stored = rsp_stored_ff;

endmodule

// ===== design/poisson_disc_accept_insert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poisson_disc_accept_insert
// Candidate test and insertion engine for Poisson disc sampling
// ----------------------------------------------------------------------------
// channel   ports                                   handshake
// request   req_operation, req_candidate_x/_y       start high while busy low
// response  rsp_status, rsp_point_index,            rsp_valid, one cycle
//           rsp_points_stored
// config    csr_index, csr_data                     csr_write, no wait
//
// a clear or out-of-region transaction is answered without a scan; a test
// visits each cell of the 5x5 window, clipped to the grid, in turn (range
// check, grid read, point read, square and compare)
// the front takes the next transaction while the back still scans; busy
// stays high while a taken transaction waits for room in the two-entry queue
// a clear only zeroes the point count: grid marks are checked against the
// point store; after reset the back zeroes all 4096 grid entries before it
// takes the first transaction
// reset is synchronous; responses cannot be held off
// ----------------------------------------------------------------------------
module poisson_disc_accept_insert import pda_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_operation,
   input  logic [COORD_BITS-1:0] req_candidate_x,
   input  logic [COORD_BITS-1:0] req_candidate_y,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [GRID_AW-1:0]    rsp_point_index,
   output logic [CNT_W-1:0]      rsp_points_stored,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_data
);

   cfg_type    cfg_ff;
   logic       push, full, pop, empty;
   qentry_type push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.region_width    <= REGION_W'(65536);
         cfg_ff.region_height   <= REGION_W'(65536);
         cfg_ff.min_distance    <= REGION_W'(2560);
         cfg_ff.cell_reciprocal <= RECIP_W'(9268);
         cfg_ff.grid_cols       <= DIM_W'(37);
         cfg_ff.grid_rows       <= DIM_W'(37);
      end else if (csr_write) begin
         case (csr_index)
            CSR_REGION_WIDTH:  cfg_ff.region_width    <= csr_data[REGION_W-1:0];
            CSR_REGION_HEIGHT: cfg_ff.region_height   <= csr_data[REGION_W-1:0];
            CSR_MIN_DISTANCE:  cfg_ff.min_distance    <= csr_data[REGION_W-1:0];
            CSR_CELL_RECIP:    cfg_ff.cell_reciprocal <= csr_data[RECIP_W-1:0];
            CSR_GRID_COLS:     cfg_ff.grid_cols       <= csr_data[DIM_W-1:0];
            CSR_GRID_ROWS:     cfg_ff.grid_rows       <= csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   pda_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_candidate_x (req_candidate_x),
      .req_candidate_y (req_candidate_y),
      .push            (push),
      .push_data       (push_data),
      .full            (full)
   );

   pda_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   pda_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .empty             (empty),
      .pop_data          (pop_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_point_index   (rsp_point_index),
      .rsp_points_stored (rsp_points_stored)
   );

endmodule
